[rtl/core/penalty_based_irq_allocator_assert.svh]
// Assertion macros shared by the allocator RTL.
`ifndef PENALTY_BASED_IRQ_ALLOCATOR_ASSERT_SVH
`define PENALTY_BASED_IRQ_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define PBIA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator assertion failed");

// Next-cycle implication.
`define PBIA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator assertion failed");

`endif

[rtl/core/pbia_pkg.sv]
// Types, codes and reset penalties for the IRQ allocator.
package pbia_pkg;

	localparam int IRQ_W = 8;
	localparam int PEN_W = 32;

	localparam logic [PEN_W-1:0] PEN_PCI_USING   = 32'd4096;      // 16^3
	localparam logic [PEN_W-1:0] PEN_ISA_TYPICAL = 32'd65536;     // 16^4
	localparam logic [PEN_W-1:0] PEN_ISA_USED    = 32'd1048576;   // 16^5
	localparam logic [PEN_W-1:0] PEN_ISA_ALWAYS  = 32'd16777216;  // 16^6

	localparam logic [1:0] KIND_PLAIN = 2'd0;
	localparam logic [1:0] KIND_EXT   = 2'd1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_IRQ_ZERO = 2'd1,
		ST_BAD_KIND = 2'd2
	} status_t;

	typedef struct packed {
		logic [IRQ_W-1:0] possible_irq;
		logic [IRQ_W-1:0] current_irq;
		logic             last_entry;
		logic             link_initialized;
		logic [1:0]       resource_kind;
	} item_t;

	typedef struct packed {
		logic [IRQ_W-1:0] chosen_irq;
		status_t          status;
	} result_t;

	typedef struct packed {
		logic             en;
		logic [IRQ_W-1:0] irq;
		logic [PEN_W-1:0] data;
	} pen_wr_t;

	// Penalty of an entry that was never written since reset.
	function automatic logic [PEN_W-1:0] isa_default(input logic [IRQ_W-1:0] irq);
		logic [PEN_W-1:0] v;
		v = '0;
		if (irq <= 8'd2) begin
			v = PEN_ISA_ALWAYS;
		end else if (irq <= 8'd8) begin
			v = PEN_ISA_TYPICAL;
		end else if (irq >= 8'd12 && irq <= 8'd15) begin
			v = PEN_ISA_USED;
		end
		return v;
	endfunction

endpackage

[rtl/core/pbia_ram.sv]
// Generic RAM: one write port, two registered read ports.
module pbia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

[rtl/core/pbia_choose.sv]
// Per-request tracking of the least-penalty entry and the final IRQ choice.
module pbia_choose import pbia_pkg::*; #(
	parameter int PENALTY_ENTRIES = 256,
	parameter int MAX_POSSIBLE    = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  item_t            item,
	input  logic [PEN_W-1:0] pen_item,
	input  logic [PEN_W-1:0] pen_cur,
	input  logic             balance_mode,
	output result_t          res,
	output pen_wr_t          wr
);

	localparam int CW = $clog2(MAX_POSSIBLE + 1);

	logic [IRQ_W-1:0] best_irq_q;
	logic [PEN_W-1:0] best_pen_q;
	logic             found_q;
	logic [CW-1:0]    cnt_q;

	logic             take;
	logic             best_upd;
	logic [IRQ_W-1:0] best_irq_n;
	logic [PEN_W-1:0] best_pen_n;
	logic             found_n;
	logic [CW-1:0]    cnt_n;
	logic [IRQ_W-1:0] active;
	logic             use_best;
	logic [IRQ_W-1:0] irq_sel;
	logic [PEN_W-1:0] pen_sel;
	logic [PEN_W:0]   pen_sum;
	logic             irq_in_range;

	always_comb begin
		take       = cnt_q < CW'(MAX_POSSIBLE);
		best_upd   = take && (cnt_q == '0 || pen_item <= best_pen_q);
		best_irq_n = best_upd ? item.possible_irq : best_irq_q;
		best_pen_n = best_upd ? pen_item : best_pen_q;
		found_n    = found_q | (take && item.possible_irq == item.current_irq);
		cnt_n      = cnt_q + CW'(take);
		active     = found_n ? item.current_irq : '0;

		// Ties keep the current IRQ; an empty request falls back to active (zero).
		if (cnt_n == '0) begin
			use_best = 1'b0;
		end else if (active == '0) begin
			use_best = 1'b1;
		end else begin
			use_best = balance_mode && (best_pen_n < pen_cur);
		end
		irq_sel      = use_best ? best_irq_n : active;
		pen_sel      = use_best ? best_pen_n : pen_cur;
		pen_sum      = {1'b0, pen_sel} + {1'b0, PEN_PCI_USING};
		irq_in_range = {1'b0, irq_sel} < (IRQ_W + 1)'(PENALTY_ENTRIES);

		res.chosen_irq = irq_sel;
		res.status     = ST_OK;
		wr.en          = 1'b0;
		wr.irq         = irq_sel;
		wr.data        = pen_sum[PEN_W] ? '1 : pen_sum[PEN_W-1:0];

		if (item.link_initialized) begin
			res.chosen_irq = item.current_irq;
			res.status     = (item.current_irq != '0) ? ST_OK : ST_IRQ_ZERO;
		end else if (irq_sel == '0) begin
			res.status = ST_IRQ_ZERO;
		end else if (item.resource_kind > KIND_EXT) begin
			res.status     = ST_BAD_KIND;
			res.chosen_irq = '0;
		end else begin
			wr.en = fire && item.last_entry && irq_in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_irq_q <= '0;
			best_pen_q <= '1;
			found_q    <= 1'b0;
			cnt_q      <= '0;
		end else if (fire) begin
			if (item.last_entry) begin
				best_irq_q <= '0;
				best_pen_q <= '1;
				found_q    <= 1'b0;
				cnt_q      <= '0;
			end else begin
				best_irq_q <= best_irq_n;
				best_pen_q <= best_pen_n;
				found_q    <= found_n;
				cnt_q      <= cnt_n;
			end
		end
	end

endmodule

[rtl/core/penalty_based_irq_allocator.sv]
// Top level of the least-penalty IRQ allocator.
//
// Input stream s_*: one possible IRQ per item, s_tlast on the final item of a
// link request. Output stream m_*: one result per request, issued for the
// item that carries s_tlast. cfg_wr_en/cfg_wr_data write balance_mode.
//
// An accepted item reads the penalty RAM at its possible IRQ and at the
// link's current IRQ; the next cycle the registered read data is compared
// against the running best and, for the last item, the choice is made and
// the chosen entry's penalty is written back. m_tdata registers the result
// as the last item leaves the compare stage. One item per cycle unless
// the output stalls; a write-back is forwarded to a read in the same cycle.
//
// Reset clears the request state, balance_mode and one valid bit per table
// entry; an entry not yet written reads as its ISA default penalty, so the
// block takes items right after reset. If the output is stalled, a last item
// waits in the compare stage and s_tready drops; earlier items keep flowing.
`include "penalty_based_irq_allocator_assert.svh"

module penalty_based_irq_allocator import pbia_pkg::*; #(
	parameter int PENALTY_ENTRIES = 256,
	parameter int MAX_POSSIBLE    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // possible_irq[7:0], current_irq[15:8], link_initialized[16]
	input  logic        s_tlast,   // last_entry
	input  logic [1:0]  s_tuser,   // resource_kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // chosen_irq[7:0], status[9:8]
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data
);

	localparam int AW = $clog2(PENALTY_ENTRIES);

	item_t            s_item;
	logic             acc;
	logic             out_free;
	logic             s1_fire;
	logic             oor_a;
	logic             oor_b;
	logic             hit_a;
	logic             hit_b;

	logic             balance_q;
	logic [PENALTY_ENTRIES-1:0] valid_q;

	logic             vld_s1;
	item_t            item_s1;
	logic             oor_a_s1;
	logic             oor_b_s1;
	logic             hit_a_s1;
	logic             hit_b_s1;
	logic             val_a_s1;
	logic             val_b_s1;
	logic [PEN_W-1:0] fwd_s1;
	logic [PEN_W-1:0] ram_a;
	logic [PEN_W-1:0] ram_b;
	logic [PEN_W-1:0] pen_item;
	logic [PEN_W-1:0] pen_cur;

	result_t          res;
	pen_wr_t          wr;
	logic             m_tvalid_q;
	logic [15:0]      m_tdata_q;

	assign s_item.possible_irq     = s_tdata[7:0];
	assign s_item.current_irq      = s_tdata[15:8];
	assign s_item.link_initialized = s_tdata[16];
	assign s_item.last_entry       = s_tlast;
	assign s_item.resource_kind    = s_tuser;

	assign out_free = !m_tvalid_q || m_tready;
	assign s1_fire  = vld_s1 && (!item_s1.last_entry || out_free);
	assign s_tready = !vld_s1 || s1_fire;
	assign acc      = s_tvalid && s_tready;

	assign oor_a = {1'b0, s_item.possible_irq} >= (IRQ_W + 1)'(PENALTY_ENTRIES);
	assign oor_b = {1'b0, s_item.current_irq} >= (IRQ_W + 1)'(PENALTY_ENTRIES);
	// A write-back landing on the same edge as the read is not seen by the RAM.
	assign hit_a = wr.en && wr.irq == s_item.possible_irq;
	assign hit_b = wr.en && wr.irq == s_item.current_irq;

	pbia_ram #(
		.WIDTH (PEN_W),
		.DEPTH (PENALTY_ENTRIES)
	) u_pen_ram (
		.clk     (clk),
		.we      (wr.en),
		.waddr   (wr.irq[AW-1:0]),
		.wdata   (wr.data),
		.re      (acc),
		.raddr_a (s_item.possible_irq[AW-1:0]),
		.raddr_b (s_item.current_irq[AW-1:0]),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			balance_q <= 1'b0;
			valid_q   <= '0;
			vld_s1    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				balance_q <= cfg_wr_data;
			end
			if (wr.en) begin
				valid_q[wr.irq[AW-1:0]] <= 1'b1;
			end
			if (acc) begin
				vld_s1 <= 1'b1;
			end else if (s1_fire) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1  <= s_item;
			oor_a_s1 <= oor_a;
			oor_b_s1 <= oor_b;
			hit_a_s1 <= hit_a;
			hit_b_s1 <= hit_b;
			val_a_s1 <= oor_a ? 1'b0 : valid_q[s_item.possible_irq[AW-1:0]];
			val_b_s1 <= oor_b ? 1'b0 : valid_q[s_item.current_irq[AW-1:0]];
			fwd_s1   <= wr.data;
		end
	end

	always_comb begin
		if (oor_a_s1) begin
			pen_item = '1;
		end else if (hit_a_s1) begin
			pen_item = fwd_s1;
		end else if (val_a_s1) begin
			pen_item = ram_a;
		end else begin
			pen_item = isa_default(item_s1.possible_irq);
		end
		if (oor_b_s1) begin
			pen_cur = '1;
		end else if (hit_b_s1) begin
			pen_cur = fwd_s1;
		end else if (val_b_s1) begin
			pen_cur = ram_b;
		end else begin
			pen_cur = isa_default(item_s1.current_irq);
		end
	end

	pbia_choose #(
		.PENALTY_ENTRIES (PENALTY_ENTRIES),
		.MAX_POSSIBLE    (MAX_POSSIBLE)
	) u_choose (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (s1_fire),
		.item         (item_s1),
		.pen_item     (pen_item),
		.pen_cur      (pen_cur),
		.balance_mode (balance_q),
		.res          (res),
		.wr           (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s1_fire && item_s1.last_entry) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && item_s1.last_entry) begin
			m_tdata_q <= {6'b0, res.status, res.chosen_irq};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`PBIA_ASSERT_IMP(a_err_irq_zero, m_tvalid && m_tdata[9:8] != ST_OK, m_tdata[7:0] == 8'd0)
	`PBIA_ASSERT_IMP(a_wr_on_last, wr.en, s1_fire && item_s1.last_entry)
	`PBIA_ASSERT_IMP(a_wr_floor, wr.en, wr.data >= PEN_PCI_USING)
	`PBIA_ASSERT_IMP(a_stall_cause, !s_tready, vld_s1 && item_s1.last_entry && m_tvalid_q)
	`PBIA_ASSERT_NXT(a_result_follows, s1_fire && item_s1.last_entry, m_tvalid)

endmodule
